// ===== src/btfl_pkg.sv =====
// Shared types, constants and helpers for the box transfer function lookup block.
package btfl_pkg;

  localparam int MaxBoxes = 16;
  localparam int IdxW     = $clog2(MaxBoxes);
  localparam int CntW     = $clog2(MaxBoxes + 1);
  localparam int MaxDim   = 1024;
  localparam int DimW     = 11;
  localparam int PixW     = 10;
  localparam int QW       = 17;
  localparam int QFrac    = 16;
  localparam int ByteW    = 8;
  localparam int RgbaW    = 4 * ByteW;
  localparam int MulAW    = 25;
  localparam int MulBW    = 17;
  localparam int ProdW    = MulAW + MulBW;
  localparam int AlphaSh  = 2 * QFrac;
  localparam int StepW    = 4;
  localparam int CmdW     = 2;
  localparam int StatW    = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgW     = 17;
  localparam int InDataW  = 160;
  localparam int OutDataW = RgbaW;

  localparam logic [ByteW-1:0] ByteMax  = 8'hFF;
  localparam logic [QW-1:0]    QOne     = 17'h10000;
  localparam logic [StepW-1:0] LastStep = StepW'(9);

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_NOT_COVERED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_QRY,
    S_RES
  } state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEX_WIDTH  = 2'd0,
    CFG_TEX_HEIGHT = 2'd1,
    CFG_OPACITY    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DimW-1:0] x0;
    logic [DimW-1:0] x1;
    logic [DimW-1:0] y0;
    logic [DimW-1:0] y1;
  } bounds_t;

  // Texture size clamped to 1 .. MaxDim.
  function automatic logic [DimW-1:0] eff_size(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > DimW'(MaxDim)) r = DimW'(MaxDim);
    return r;
  endfunction

  function automatic logic [QW-1:0] sat_q(input logic [QW-1:0] c);
    return (c > QOne) ? QOne : c;
  endfunction

  // floor(q * size / 2^16), clipped to size.
  function automatic logic [DimW-1:0] to_pixel(input logic [ProdW-1:0] prod,
                                               input logic [DimW-1:0] size);
    logic [ProdW-QFrac-1:0] p;
    p = prod[ProdW-1:QFrac];
    return (p > (ProdW-QFrac)'(size)) ? size : p[DimW-1:0];
  endfunction

endpackage

// ===== src/box_transfer_function_lookup_top.sv =====
// Box color table: add boxes, rasterize pixel queries against the stored boxes.
//
// A user of this block writes colored boxes in normalized Q1.16 coordinates
// (cmd add) and queries single pixels (cmd query); the answer is the RGBA
// bytes of the most recently added box covering the pixel, or status
// not_covered. cmd clear empties the table of up to 16 boxes. All multiplies
// run on one shared 25x17 multiplier driven by a step counter; an add takes
// nine multiplier steps (four pixel bounds, four color bytes and a second
// pass for the opacity scaling), then the table write.
// A query reads the box table one entry per cycle, newest first, from a
// table with one write port and a registered read port, and ends early on
// the first hit; a pixel outside the texture or an empty table skips the
// table read, as do clear and the unused command code. The input is ready
// again from the edge that loads the result into the output register; a
// result waiting there does not block the next item. Texture sizes and
// opacity scale are read live, so write them only while the block is idle;
// stored bounds keep the size in force when the box was added.
module box_transfer_function_lookup_top
  import btfl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input items
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // tdata, lowest bit up: iso_x, iso_y, box_w, box_h, red, green, blue,
  // alpha (17 bits each), pix_x, pix_y (10 bits each), 4 zero bits
  input  logic [InDataW-1:0]   s_axis_tdata_i,
  // tuser: cmd
  input  logic [CmdW-1:0]      s_axis_tuser_i,
  // Result items
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // tdata, lowest bit up: out_red, out_green, out_blue, out_alpha
  output logic [OutDataW-1:0]  m_axis_tdata_o,
  // tuser: status
  output logic [StatW-1:0]     m_axis_tuser_o,
  // Register writes
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Input field slices
  // ---------------------------------------------------------------------------
  logic [QW-1:0]   in_iso_x, in_iso_y, in_box_w, in_box_h;
  logic [QW-1:0]   in_red, in_green, in_blue, in_alpha;
  logic [PixW-1:0] in_pix_x, in_pix_y;

  assign in_iso_x = s_axis_tdata_i[16:0];
  assign in_iso_y = s_axis_tdata_i[33:17];
  assign in_box_w = s_axis_tdata_i[50:34];
  assign in_box_h = s_axis_tdata_i[67:51];
  assign in_red   = s_axis_tdata_i[84:68];
  assign in_green = s_axis_tdata_i[101:85];
  assign in_blue  = s_axis_tdata_i[118:102];
  assign in_alpha = s_axis_tdata_i[135:119];
  assign in_pix_x = s_axis_tdata_i[145:136];
  assign in_pix_y = s_axis_tdata_i[155:146];

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [DimW-1:0]  tex_w_q, tex_h_q;
  logic [CfgW-1:0]  scale_q;
  logic [DimW-1:0]  w_eff, h_eff;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q;
  logic [CntW-1:0]  box_cnt_q;
  logic [CntW-1:0]  left_q;
  logic             rd_vld_q;
  logic             m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic [StatW-1:0] m_user_q;

  // latched item
  logic [QW-1:0]    ix_q, iy_q, bw_q, bh_q, r_q, g_q, b_q, a_q;
  logic [PixW-1:0]  px_q, py_q;

  // shared multiplier
  logic [MulAW-1:0] op_a;
  logic [MulBW-1:0] op_b;
  logic [ProdW-1:0] prod_d, prod_q;

  // add accumulators and result staging
  bounds_t          bnd_acc_q;
  logic [RgbaW-1:0] rgba_acc_q;
  logic [StatW-1:0] res_status_q;
  logic [RgbaW-1:0] res_rgba_q;

  // box table
  bounds_t          bnd_mem [MaxBoxes];
  logic [RgbaW-1:0] rgba_mem [MaxBoxes];
  bounds_t          bnd_rd_q;
  logic [RgbaW-1:0] rgba_rd_q;
  logic [IdxW-1:0]  rd_addr;
  logic [CntW-1:0]  left_dec;

  // control
  logic             s_fire, out_free, rd_en, mem_we, res_take;
  logic             q_skip, tbl_full, hit;
  logic [ByteW-1:0] alpha_byte;
  logic [ProdW-AlphaSh-1:0] alpha_hi;

  assign w_eff    = eff_size(tex_w_q);
  assign h_eff    = eff_size(tex_h_q);
  assign s_fire   = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free = ~m_valid_q | m_axis_tready_i;
  assign tbl_full = (box_cnt_q >= CntW'(MaxBoxes));

  // Query answered at once: pixel outside texture or nothing stored.
  assign q_skip = ({1'b0, in_pix_x} >= w_eff) || ({1'b0, in_pix_y} >= h_eff) ||
                  (box_cnt_q == '0);

  assign left_dec = left_q - CntW'(1);
  assign rd_addr  = left_dec[IdxW-1:0];

  assign hit = ({1'b0, px_q} >= bnd_rd_q.x0) && ({1'b0, px_q} < bnd_rd_q.x1) &&
               ({1'b0, py_q} >= bnd_rd_q.y0) && ({1'b0, py_q} < bnd_rd_q.y1);

  // ---------------------------------------------------------------------------
  // Multiplier operand select, one step per cycle
  //   0..3: pixel bounds x0, x1, y0, y1   4..7: c * 255   8: (a*255) * scale
  // ---------------------------------------------------------------------------
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_q)
      4'd0: begin
        op_a = MulAW'(ix_q);
        op_b = MulBW'(w_eff);
      end
      4'd1: begin
        op_a = MulAW'({1'b0, ix_q} + {1'b0, bw_q});
        op_b = MulBW'(w_eff);
      end
      4'd2: begin
        op_a = MulAW'(iy_q);
        op_b = MulBW'(h_eff);
      end
      4'd3: begin
        op_a = MulAW'({1'b0, iy_q} + {1'b0, bh_q});
        op_b = MulBW'(h_eff);
      end
      4'd4: begin
        op_a = MulAW'(sat_q(r_q));
        op_b = MulBW'(ByteMax);
      end
      4'd5: begin
        op_a = MulAW'(sat_q(g_q));
        op_b = MulBW'(ByteMax);
      end
      4'd6: begin
        op_a = MulAW'(sat_q(b_q));
        op_b = MulBW'(ByteMax);
      end
      4'd7: begin
        op_a = MulAW'(sat_q(a_q));
        op_b = MulBW'(ByteMax);
      end
      4'd8: begin
        op_a = prod_q[MulAW-1:0];
        op_b = scale_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d = ProdW'(op_a) * ProdW'(op_b);

  // Alpha: floor(a*255*scale / 2^32), saturated to a byte.
  assign alpha_hi   = prod_q[ProdW-1:AlphaSh];
  assign alpha_byte = (alpha_hi > (ProdW-AlphaSh)'(ByteMax)) ? ByteMax
                                                             : alpha_hi[ByteW-1:0];

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          case (cmd_e'(s_axis_tuser_i))
            CMD_ADD:   state_d = tbl_full ? S_RES : S_ADD;
            CMD_QUERY: state_d = q_skip ? S_RES : S_QRY;
            default:   state_d = S_RES;
          endcase
        end
      end
      S_ADD: begin
        if (step_q == LastStep) state_d = S_RES;
      end
      S_QRY: begin
        if (rd_vld_q && (hit || left_q == '0)) state_d = S_RES;
      end
      S_RES: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    s_axis_tready_o = (state_q == S_IDLE);
    rd_en           = (state_q == S_QRY) && (left_q != '0);
    mem_we          = (state_q == S_ADD) && (step_q == LastStep);
    res_take        = (state_q == S_RES) && out_free;
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      box_cnt_q <= '0;
      left_q    <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
      tex_w_q   <= DimW'(256);
      tex_h_q   <= DimW'(256);
      scale_q   <= CfgW'(QOne);
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TEX_WIDTH:  tex_w_q <= cfg_data_i[DimW-1:0];
          CFG_TEX_HEIGHT: tex_h_q <= cfg_data_i[DimW-1:0];
          CFG_OPACITY:    scale_q <= cfg_data_i;
          default:        ;
        endcase
      end

      if (s_fire) begin
        step_q   <= '0;
        left_q   <= box_cnt_q;
        rd_vld_q <= 1'b0;
        if (cmd_e'(s_axis_tuser_i) == CMD_CLEAR) box_cnt_q <= '0;
      end

      if (state_q == S_ADD) step_q <= step_q + StepW'(1);
      if (mem_we) box_cnt_q <= box_cnt_q + CntW'(1);

      if (state_q == S_QRY) begin
        rd_vld_q <= rd_en;
        if (rd_en) left_q <= left_dec;
      end

      if (res_take) m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      ix_q <= in_iso_x;
      iy_q <= in_iso_y;
      bw_q <= in_box_w;
      bh_q <= in_box_h;
      r_q  <= in_red;
      g_q  <= in_green;
      b_q  <= in_blue;
      a_q  <= in_alpha;
      px_q <= in_pix_x;
      py_q <= in_pix_y;
      res_rgba_q <= '0;
      case (cmd_e'(s_axis_tuser_i))
        CMD_ADD:   res_status_q <= tbl_full ? ST_FULL : ST_OK;
        CMD_QUERY: res_status_q <= ST_NOT_COVERED;
        default:   res_status_q <= ST_OK;
      endcase
    end

    if (state_q == S_ADD) begin
      prod_q <= prod_d;
      // write back the step issued in the previous cycle
      case (step_q)
        4'd1: bnd_acc_q.x0 <= to_pixel(prod_q, w_eff);
        4'd2: bnd_acc_q.x1 <= to_pixel(prod_q, w_eff);
        4'd3: bnd_acc_q.y0 <= to_pixel(prod_q, h_eff);
        4'd4: bnd_acc_q.y1 <= to_pixel(prod_q, h_eff);
        4'd5: rgba_acc_q[ByteW-1:0]         <= prod_q[QFrac+ByteW-1:QFrac];
        4'd6: rgba_acc_q[2*ByteW-1:ByteW]   <= prod_q[QFrac+ByteW-1:QFrac];
        4'd7: rgba_acc_q[3*ByteW-1:2*ByteW] <= prod_q[QFrac+ByteW-1:QFrac];
        default: ;
      endcase
      if (mem_we) res_status_q <= ST_OK;
    end

    if (state_q == S_QRY && rd_vld_q && hit) begin
      res_status_q <= ST_OK;
      res_rgba_q   <= rgba_rd_q;
    end

    if (res_take) begin
      m_data_q <= res_rgba_q;
      m_user_q <= res_status_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Box table: one write port, one registered read port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bnd_mem[box_cnt_q[IdxW-1:0]]  <= bnd_acc_q;
      rgba_mem[box_cnt_q[IdxW-1:0]] <= {alpha_byte, rgba_acc_q[3*ByteW-1:0]};
    end
    if (rd_en) begin
      bnd_rd_q  <= bnd_mem[rd_addr];
      rgba_rd_q <= rgba_mem[rd_addr];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

// ===== src/btfl_checker.sv =====
// Port-level checks for the box transfer function lookup block, bound to the top level.
module btfl_checker
  import btfl_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic [StatW-1:0]    m_axis_tuser_o
);

  logic s_fire;
  assign s_fire = s_axis_tvalid_i & s_axis_tready_o;

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready_o)
    else $error("input ready right after an accept");

  // no result becomes valid right after the accept that brought its item in
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !$rose(m_axis_tvalid_o))
    else $error("result valid rose one cycle after accept");

  // only a covered query carries color bytes
  a_zero_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != ST_OK) |-> (m_axis_tdata_o == '0))
    else $error("color bytes on a result that is not a covered pixel");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind box_transfer_function_lookup_top btfl_checker u_btfl_checker (.*);

// ===== tb/sv/box_transfer_function_lookup_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the box color table: directed cases, resize and random traffic vs a predictor.
module box_transfer_function_lookup_top_tb;
  import btfl_pkg::*;

  localparam int ClkHalf      = 10;
  localparam int ResetCycles  = 7;
  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 4;    // margin after the last result before a register write
  localparam int DrainCycles  = 40;   // drain margin at the end of the run
  localparam int RandomItems  = 1350;
  localparam int NumPhases    = 9;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam logic [QW-1:0]   QHalf     = 17'h08000;
  localparam logic [QW-1:0]   QFieldMax = 17'h1FFFF;

  // One input item, fields as the block sees them.
  typedef struct {
    logic [CmdW-1:0] cmd;
    logic [QW-1:0]   iso_x, iso_y, box_w, box_h;
    logic [QW-1:0]   red, green, blue, alpha;
    logic [PixW-1:0] pix_x, pix_y;
  } box_item_t;

  // One result item: status plus color bytes, red in byte 0.
  typedef struct {
    status_e                 status;
    logic [3:0][ByteW-1:0]   rgba;
  } pixel_color_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  // iso_x, iso_y, box_w, box_h, red, green, blue, alpha, pix_x, pix_y, pad
  logic [InDataW-1:0]  in_data = '0;
  // cmd
  logic [CmdW-1:0]     in_cmd = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  // out_red, out_green, out_blue, out_alpha
  logic [OutDataW-1:0] out_data;
  // status
  logic [StatW-1:0]    out_status;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgW-1:0]     cfg_data = '0;

  // Predictor copy of registers and box table.
  logic [DimW-1:0]             tex_w_reg = DimW'(256);
  logic [DimW-1:0]             tex_h_reg = DimW'(256);
  logic [CfgW-1:0]             opacity_reg = QOne;
  logic [DimW-1:0]             bx0 [MaxBoxes];
  logic [DimW-1:0]             bx1 [MaxBoxes];
  logic [DimW-1:0]             by0 [MaxBoxes];
  logic [DimW-1:0]             by1 [MaxBoxes];
  logic [3:0][ByteW-1:0]       box_color [MaxBoxes];
  int                          box_total = 0;

  pixel_color_t colors_due [$];   // predicted results, oldest first
  int           mismatches = 0;
  int           cycles = 0;
  bit           steady = 1'b0;    // set: no gaps on either side
  int           sink_stall = 0;

  box_transfer_function_lookup_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_cmd),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_status),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Texture size register -> effective size 1 .. MaxDim.
  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v);
    if (v == '0) return DimW'(1);
    if (v > DimW'(MaxDim)) return DimW'(MaxDim);
    return v;
  endfunction

  // Normalized coordinate (may exceed one) -> pixel bound, clipped to size.
  function automatic logic [DimW-1:0] bound_px(logic [QW:0] q, logic [DimW-1:0] size);
    logic [63:0] p;
    p = (64'(q) * 64'(size)) >> QFrac;
    return (p > 64'(size)) ? size : DimW'(p);
  endfunction

  function automatic logic [QW-1:0] clip_one(logic [QW-1:0] c);
    return (c > QOne) ? QOne : c;
  endfunction

  function automatic logic [ByteW-1:0] q_byte(logic [QW-1:0] c);
    logic [63:0] p;
    p = (64'(clip_one(c)) * 64'd255) >> QFrac;
    return ByteW'(p);
  endfunction

  // Applies one item to the predicted table and returns the result it causes.
  function automatic pixel_color_t predict_color(box_item_t it);
    pixel_color_t    r;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
    logic [63:0]     sa;
    bit              hit;
    r.status = ST_OK;
    r.rgba   = '0;
    w   = clamp_dim(tex_w_reg);
    h   = clamp_dim(tex_h_reg);
    hit = 1'b0;
    if (it.cmd == CMD_CLEAR) begin
      box_total = 0;
    end else if (it.cmd == CMD_ADD) begin
      if (box_total >= MaxBoxes) begin
        r.status = ST_FULL;
      end else begin
        bx0[box_total] = bound_px({1'b0, it.iso_x}, w);
        bx1[box_total] = bound_px({1'b0, it.iso_x} + it.box_w, w);
        by0[box_total] = bound_px({1'b0, it.iso_y}, h);
        by1[box_total] = bound_px({1'b0, it.iso_y} + it.box_h, h);
        sa = (64'(clip_one(it.alpha)) * 64'd255 * 64'(opacity_reg)) >> AlphaSh;
        box_color[box_total] = {(sa > 64'd255) ? ByteMax : sa[ByteW-1:0],
                                q_byte(it.blue), q_byte(it.green), q_byte(it.red)};
        box_total++;
      end
    end else if (it.cmd == CMD_QUERY) begin
      r.status = ST_NOT_COVERED;
      // newest box wins; pixels outside the current texture never hit
      if (it.pix_x < w && it.pix_y < h) begin
        for (int i = box_total - 1; i >= 0 && !hit; i--) begin
          if (bx0[i] <= it.pix_x && it.pix_x < bx1[i] &&
              by0[i] <= it.pix_y && it.pix_y < by1[i]) begin
            hit      = 1'b1;
            r.status = ST_OK;
            r.rgba   = box_color[i];
          end
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------

  // All fields random, including the ones the command ignores.
  function automatic box_item_t bare_item(logic [CmdW-1:0] cmd);
    box_item_t it;
    it.cmd   = cmd;
    it.iso_x = QW'($urandom);
    it.iso_y = QW'($urandom);
    it.box_w = QW'($urandom);
    it.box_h = QW'($urandom);
    it.red   = QW'($urandom);
    it.green = QW'($urandom);
    it.blue  = QW'($urandom);
    it.alpha = QW'($urandom);
    it.pix_x = PixW'($urandom);
    it.pix_y = PixW'($urandom);
    return it;
  endfunction

  function automatic box_item_t add_item(logic [QW-1:0] ix, logic [QW-1:0] iy,
                                         logic [QW-1:0] bw, logic [QW-1:0] bh,
                                         logic [QW-1:0] r, logic [QW-1:0] g,
                                         logic [QW-1:0] b, logic [QW-1:0] a);
    box_item_t it;
    it = bare_item(CMD_ADD);
    it.iso_x = ix;
    it.iso_y = iy;
    it.box_w = bw;
    it.box_h = bh;
    it.red   = r;
    it.green = g;
    it.blue  = b;
    it.alpha = a;
    return it;
  endfunction

  function automatic box_item_t query_item(logic [PixW-1:0] px, logic [PixW-1:0] py);
    box_item_t it;
    it = bare_item(CMD_QUERY);
    it.pix_x = px;
    it.pix_y = py;
    return it;
  endfunction

  // Color component: zero, one, above one (saturates) or in range.
  function automatic logic [QW-1:0] rand_color();
    case ($urandom_range(7))
      0:       return '0;
      1:       return QOne;
      2:       return QW'($urandom_range(QFieldMax, QOne + 1));
      default: return QW'($urandom_range(QOne));
    endcase
  endfunction

  // Mostly boxes starting inside the unit square with sizes spread over five octaves.
  function automatic box_item_t random_add();
    box_item_t it;
    it = bare_item(CMD_ADD);
    if ($urandom_range(4) != 0) begin
      it.iso_x = QW'($urandom_range(QOne));
      it.iso_y = QW'($urandom_range(QOne));
      it.box_w = QW'($urandom_range(QOne >> $urandom_range(4)));
      it.box_h = QW'($urandom_range(QOne >> $urandom_range(4)));
      it.red   = rand_color();
      it.green = rand_color();
      it.blue  = rand_color();
      it.alpha = rand_color();
    end
    return it;
  endfunction

  // Half the queries aim inside a stored box, most of the rest inside the texture.
  function automatic box_item_t random_query();
    box_item_t it;
    int        sel;
    int        i;
    it  = bare_item(CMD_QUERY);
    sel = $urandom_range(9);
    if (sel < 5 && box_total > 0) begin
      i = $urandom_range(box_total - 1);
      if (bx1[i] > bx0[i] && by1[i] > by0[i]) begin
        it.pix_x = PixW'($urandom_range(bx1[i] - 1, bx0[i]));
        it.pix_y = PixW'($urandom_range(by1[i] - 1, by0[i]));
      end
    end else if (sel < 8) begin
      it.pix_x = PixW'($urandom_range(clamp_dim(tex_w_reg) - 1));
      it.pix_y = PixW'($urandom_range(clamp_dim(tex_h_reg) - 1));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Drives one item at the falling edge, waits for the handshake, then
  // records what the block has to answer.
  task automatic send_item(box_item_t it);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= it.cmd;
    in_data  <= {4'b0, it.pix_y, it.pix_x, it.alpha, it.blue, it.green, it.red,
                 it.box_h, it.box_w, it.iso_y, it.iso_x};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    colors_due.push_back(predict_color(it));
  endtask

  // Every item yields one result, so an empty queue means the block is idle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TEX_WIDTH:  tex_w_reg = value[DimW-1:0];
      CFG_TEX_HEIGHT: tex_h_reg = value[DimW-1:0];
      CFG_OPACITY:    opacity_reg = value;
      default: ;
    endcase
  endtask

  task automatic set_texture(logic [DimW-1:0] w, logic [DimW-1:0] h, logic [CfgW-1:0] op);
    wait_idle();
    write_reg(CFG_TEX_WIDTH, CfgW'(w));
    write_reg(CFG_TEX_HEIGHT, CfgW'(h));
    write_reg(CFG_OPACITY, op);
  endtask

  // Result side: random stalls, none while steady is set.
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      out_ready <= 1'b0;
      sink_stall--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(3) == 0) sink_stall = idle_len();
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    pixel_color_t want;
    if (out_valid && out_ready) begin
      if (colors_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, status %0d data %h", $time, out_status, out_data);
      end else begin
        want = colors_due.pop_front();
        if (out_status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        end
        // byte 0 red, 1 green, 2 blue, 3 alpha
        for (int k = 0; k < 4; k++) begin
          if (out_data[k*ByteW +: ByteW] !== want.rgba[k]) begin
            mismatches++;
            $display("%0t: color byte %0d expected %0d actual %0d", $time, k,
                     want.rgba[k], out_data[k*ByteW +: ByteW]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Runs on reset register values: 256 x 256, opacity one.
  task automatic test_directed_cases();
    send_item(query_item(0, 0));                                   // empty table
    send_item(add_item(0, 0, QOne, QOne, QOne, QOne, QOne, QOne)); // whole texture, white
    send_item(query_item(0, 0));
    send_item(query_item(255, 255));
    send_item(query_item(256, 0));                                 // just outside texture
    send_item(query_item(0, 1023));
    // start beyond one clips to an empty box; colors above one saturate
    send_item(add_item(QFieldMax, QFieldMax, QFieldMax, QFieldMax,
                       QFieldMax, QFieldMax, QFieldMax, QFieldMax));
    send_item(add_item(0, 0, 0, 0, 0, 0, 0, 0));                   // zero size box
    // one black pixel at (128,128) over the white box
    send_item(add_item(QHalf, QHalf, 17'h100, 17'h100, 0, 0, 0, 0));
    send_item(query_item(128, 128));
    send_item(query_item(129, 128));
    send_item(bare_item(CmdUnused));
    // fill the table, then one add too many
    for (int n = 4; n <= MaxBoxes; n++) send_item(random_add());
    send_item(bare_item(CMD_CLEAR));
    send_item(query_item(0, 0));
  endtask

  // Stored bounds keep the texture size of the moment they were added.
  task automatic test_resize_keeps_bounds();
    set_texture(256, 256, QOne);
    send_item(bare_item(CMD_CLEAR));
    send_item(add_item(0, 0, QHalf, QHalf, QOne, QHalf, 0, QHalf)); // pixels 0..127
    set_texture(1024, 1024, QOne);
    send_item(query_item(127, 127));
    send_item(query_item(128, 0));
    set_texture(64, 64, QOne);
    send_item(query_item(100, 0));   // inside stored box, outside texture
    send_item(query_item(63, 63));
  endtask

  task automatic run_traffic(int items);
    int r;
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(99);
      if (r < 4) send_item(bare_item(CMD_CLEAR));
      else if (r < 7) send_item(bare_item(CmdUnused));
      else if (r < 42) send_item(random_add());
      else send_item(random_query());
    end
  endtask

  // Phases over register settings, extremes first; some phases run gap-free.
  task automatic test_random_traffic();
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: set_texture(256, 256, QOne);
        1: set_texture(0, 1, 0);
        2: set_texture(1, 1024, QOne - 1);
        3: set_texture(1024, 1024, QFieldMax);
        4: set_texture(2047, 0, QHalf);
        5: set_texture(3, 5, QOne);
        default: set_texture(DimW'($urandom_range(1024, 1)), DimW'($urandom_range(1024, 1)),
                             CfgW'($urandom_range(QFieldMax)));
      endcase
      steady = ($urandom_range(3) == 0);
      run_traffic(RandomItems / NumPhases);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_resize_keeps_bounds();
    test_random_traffic();
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== box_transfer_function_lookup_top.f =====
src/btfl_pkg.sv
src/box_transfer_function_lookup_top.sv
src/btfl_checker.sv
tb/sv/box_transfer_function_lookup_top_tb.sv
